// ===== rtl/lcl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lcl_pkg;

   // Coordinate and derived widths
   localparam int COORD_W   = 16;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int DEN_W     = COORD_W;
   localparam int DREM_W    = COORD_W + 1;
   localparam int SQ_W      = 2 * COORD_W;
   localparam int SUM_W     = SQ_W + 1;
   localparam int RAD_W     = 50;
   localparam int ROOT_W    = 25;
   localparam int SREM_W    = ROOT_W + 3;
   localparam int LEN_W     = 25;
   localparam int NUM_EDGES = 4;

   // Edge order: left, right, top, bottom
   localparam int EDGE_LEFT   = 0;
   localparam int EDGE_RIGHT  = 1;
   localparam int EDGE_TOP    = 2;
   localparam int EDGE_BOTTOM = 3;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic signed [COORD_W-1:0] rect_left;
      logic signed [COORD_W-1:0] rect_top;
      logic signed [COORD_W-1:0] rect_right;
      logic signed [COORD_W-1:0] rect_bottom;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0] clipped_length;
      logic             accepted;
   } rsp_type;

   // Per-edge decision flags that travel with the divider data
   typedef struct packed {
      logic entry;   // ratio is a candidate for t1
      logic leave;   // ratio is a candidate for t2
      logic reject;  // edge rejects the segment on its own
   } edge_flags_type;

   typedef edge_flags_type [NUM_EDGES-1:0] edge_set_type;

endpackage

`default_nettype wire

// ===== rtl/lcl_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lcl_prep (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire lcl_pkg::req_type in_req,
   output logic                  out_valid,
   output lcl_pkg::edge_set_type out_ctl,
   output logic [lcl_pkg::DEN_W-1:0] out_den [lcl_pkg::NUM_EDGES],
   output logic [lcl_pkg::DEN_W-1:0] out_num [lcl_pkg::NUM_EDGES],
   output logic [lcl_pkg::RAD_W-1:0] out_rad
);
   import lcl_pkg::*;

   // Stage 1: coordinate differences
   logic                     v1_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff;
   logic signed [DIFF_W-1:0] q1_ff [NUM_EDGES];

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= in_valid;
      dx_ff <= DIFF_W'(in_req.end_x) - DIFF_W'(in_req.start_x);
      dy_ff <= DIFF_W'(in_req.end_y) - DIFF_W'(in_req.start_y);
      q1_ff[EDGE_LEFT]   <= DIFF_W'(in_req.start_x) - DIFF_W'(in_req.rect_left);
      q1_ff[EDGE_RIGHT]  <= DIFF_W'(in_req.rect_right) - DIFF_W'(in_req.start_x);
      q1_ff[EDGE_TOP]    <= DIFF_W'(in_req.start_y) - DIFF_W'(in_req.rect_top);
      q1_ff[EDGE_BOTTOM] <= DIFF_W'(in_req.rect_bottom) - DIFF_W'(in_req.start_y);
   end

   // Stage 2: magnitudes and signs
   logic             v2_ff;
   logic [DEN_W-1:0] adx_ff, ady_ff;
   logic [DEN_W-1:0] qabs_ff [NUM_EDGES];
   logic             qneg_ff [NUM_EDGES];
   logic             xneg_ff, xzero_ff, yneg_ff, yzero_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      adx_ff   <= dx_ff[DIFF_W-1] ? DEN_W'(-dx_ff) : DEN_W'(dx_ff);
      ady_ff   <= dy_ff[DIFF_W-1] ? DEN_W'(-dy_ff) : DEN_W'(dy_ff);
      xneg_ff  <= dx_ff[DIFF_W-1];
      yneg_ff  <= dy_ff[DIFF_W-1];
      xzero_ff <= (dx_ff == '0);
      yzero_ff <= (dy_ff == '0);
      for (int e = 0; e < NUM_EDGES; e++) begin
         qabs_ff[e] <= q1_ff[e][DIFF_W-1] ? DEN_W'(-q1_ff[e]) : DEN_W'(q1_ff[e]);
         qneg_ff[e] <= q1_ff[e][DIFF_W-1];
      end
   end

   // Stage 3: edge decisions, clamped numerators, squares
   logic             v3_ff;
   edge_set_type     ctl3_ff, ctl3_in;
   logic [DEN_W-1:0] den3_ff [NUM_EDGES];
   logic [DEN_W-1:0] num3_ff [NUM_EDGES];
   logic [DEN_W-1:0] den3_in [NUM_EDGES];
   logic [DEN_W-1:0] num3_in [NUM_EDGES];
   logic [SQ_W-1:0]  sqx_ff, sqy_ff;
   logic             pneg [NUM_EDGES];
   logic             pzero [NUM_EDGES];

   always_comb begin
      den3_in[EDGE_LEFT]   = adx_ff;
      den3_in[EDGE_RIGHT]  = adx_ff;
      den3_in[EDGE_TOP]    = ady_ff;
      den3_in[EDGE_BOTTOM] = ady_ff;
      // p is -dx, dx, -dy, dy
      pneg[EDGE_LEFT]      = !xneg_ff && !xzero_ff;
      pneg[EDGE_RIGHT]     = xneg_ff;
      pneg[EDGE_TOP]       = !yneg_ff && !yzero_ff;
      pneg[EDGE_BOTTOM]    = yneg_ff;
      pzero[EDGE_LEFT]     = xzero_ff;
      pzero[EDGE_RIGHT]    = xzero_ff;
      pzero[EDGE_TOP]      = yzero_ff;
      pzero[EDGE_BOTTOM]   = yzero_ff;
      for (int e = 0; e < NUM_EDGES; e++) begin
         num3_in[e] = (qabs_ff[e] > den3_in[e]) ? den3_in[e] : qabs_ff[e];
         ctl3_in[e] = '0;
         if (pzero[e]) begin
            ctl3_in[e].reject = qneg_ff[e];
         end else if (pneg[e]) begin
            ctl3_in[e].entry  = qneg_ff[e] && !(qabs_ff[e] > den3_in[e]);
            ctl3_in[e].reject = qneg_ff[e] && (qabs_ff[e] > den3_in[e]);
         end else begin
            ctl3_in[e].reject = qneg_ff[e];
            ctl3_in[e].leave  = !qneg_ff[e] && (qabs_ff[e] < den3_in[e]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
      ctl3_ff <= ctl3_in;
      den3_ff <= den3_in;
      num3_ff <= num3_in;
      sqx_ff  <= adx_ff * adx_ff;
      sqy_ff  <= ady_ff * ady_ff;
   end

   // Stage 4: squared length, scaled to give a Q.8 root
   logic             v4_ff;
   edge_set_type     ctl4_ff;
   logic [DEN_W-1:0] den4_ff [NUM_EDGES];
   logic [DEN_W-1:0] num4_ff [NUM_EDGES];
   logic [RAD_W-1:0] rad4_ff;
   logic [SUM_W-1:0] sum_in;

   assign sum_in = SUM_W'(sqx_ff) + SUM_W'(sqy_ff);

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else       v4_ff <= v3_ff;
      ctl4_ff <= ctl3_ff;
      den4_ff <= den3_ff;
      num4_ff <= num3_ff;
      rad4_ff <= {RAD_W'(sum_in)} << 16;
   end

   assign out_valid = v4_ff;
   assign out_ctl   = ctl4_ff;
   assign out_den   = den4_ff;
   assign out_num   = num4_ff;
   assign out_rad   = rad4_ff;

endmodule

`default_nettype wire

// ===== rtl/lcl_iter.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lcl_iter #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire lcl_pkg::edge_set_type in_ctl,
   input  wire logic [lcl_pkg::DEN_W-1:0] in_den [lcl_pkg::NUM_EDGES],
   input  wire logic [lcl_pkg::DEN_W-1:0] in_num [lcl_pkg::NUM_EDGES],
   input  wire logic [lcl_pkg::RAD_W-1:0] in_rad,
   output logic                       out_valid,
   output lcl_pkg::edge_set_type      out_ctl,
   output logic [FRAC_BITS:0]         out_quo [lcl_pkg::NUM_EDGES],
   output logic [lcl_pkg::ROOT_W-1:0] out_root
);
   import lcl_pkg::*;

   localparam int QW   = FRAC_BITS + 1;
   localparam int NSTG = (ROOT_W > QW) ? ROOT_W : QW;

   // One restoring divide bit per edge and one root bit per stage
   logic              vld_ff  [NSTG];
   edge_set_type      ctl_ff  [NSTG];
   logic [DEN_W-1:0]  den_ff  [NSTG][NUM_EDGES];
   logic [DREM_W-1:0] drem_ff [NSTG][NUM_EDGES];
   logic [QW-1:0]     quo_ff  [NSTG][NUM_EDGES];
   logic [RAD_W-1:0]  rad_ff  [NSTG];
   logic [SREM_W-1:0] srem_ff [NSTG];
   logic [ROOT_W-1:0] root_ff [NSTG];

   for (genvar k = 0; k < NSTG; k++) begin : g_stg
      logic              v_src;
      edge_set_type      c_src;
      logic [DEN_W-1:0]  d_src [NUM_EDGES];
      logic [DREM_W-1:0] r_src [NUM_EDGES];
      logic [QW-1:0]     q_src [NUM_EDGES];
      logic [RAD_W-1:0]  a_src;
      logic [SREM_W-1:0] s_src;
      logic [ROOT_W-1:0] o_src;
      logic [DREM_W-1:0] drem_in [NUM_EDGES];
      logic [QW-1:0]     quo_in  [NUM_EDGES];
      logic [RAD_W-1:0]  rad_in;
      logic [SREM_W-1:0] srem_in;
      logic [ROOT_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign v_src = in_valid;
         assign c_src = in_ctl;
         assign a_src = in_rad;
         assign s_src = '0;
         assign o_src = '0;
         for (genvar e = 0; e < NUM_EDGES; e++) begin : g_e
            assign d_src[e] = in_den[e];
            assign r_src[e] = DREM_W'(in_num[e]);
            assign q_src[e] = '0;
         end
      end else begin : g_next
         assign v_src = vld_ff[k-1];
         assign c_src = ctl_ff[k-1];
         assign a_src = rad_ff[k-1];
         assign s_src = srem_ff[k-1];
         assign o_src = root_ff[k-1];
         for (genvar e = 0; e < NUM_EDGES; e++) begin : g_e
            assign d_src[e] = den_ff[k-1][e];
            assign r_src[e] = drem_ff[k-1][e];
            assign q_src[e] = quo_ff[k-1][e];
         end
      end

      always_comb begin
         logic [DREM_W-1:0] r2;
         logic              ge;
         logic [SREM_W-1:0] sh;
         logic [SREM_W-1:0] trial;
         r2    = '0;
         ge    = 1'b0;
         sh    = '0;
         trial = '0;
         // Divider step: the first step yields the integer bit
         for (int e = 0; e < NUM_EDGES; e++) begin
            if (k < QW) begin
               r2 = (k == 0) ? r_src[e] : {r_src[e][DREM_W-2:0], 1'b0};
               ge = (r2 >= DREM_W'(d_src[e]));
               drem_in[e] = ge ? (r2 - DREM_W'(d_src[e])) : r2;
               quo_in[e]  = {q_src[e][QW-2:0], ge};
            end else begin
               drem_in[e] = r_src[e];
               quo_in[e]  = q_src[e];
            end
         end
         // Root step: bring down two radicand bits, try 4*root+1
         if (k < ROOT_W) begin
            sh    = {s_src[SREM_W-3:0], a_src[RAD_W-1 -: 2]};
            trial = {1'b0, o_src, 2'b01};
            if (sh >= trial) begin
               srem_in = sh - trial;
               root_in = {o_src[ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = sh;
               root_in = {o_src[ROOT_W-2:0], 1'b0};
            end
            rad_in = {a_src[RAD_W-3:0], 2'b00};
         end else begin
            srem_in = s_src;
            root_in = o_src;
            rad_in  = a_src;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) vld_ff[k] <= 1'b0;
         else       vld_ff[k] <= v_src;
         ctl_ff[k]  <= c_src;
         den_ff[k]  <= d_src;
         drem_ff[k] <= drem_in;
         quo_ff[k]  <= quo_in;
         rad_ff[k]  <= rad_in;
         srem_ff[k] <= srem_in;
         root_ff[k] <= root_in;
      end
   end

   assign out_valid = vld_ff[NSTG-1];
   assign out_ctl   = ctl_ff[NSTG-1];
   assign out_quo   = quo_ff[NSTG-1];
   assign out_root  = root_ff[NSTG-1];

endmodule

`default_nettype wire

// ===== rtl/lcl_final.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lcl_final #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire lcl_pkg::edge_set_type in_ctl,
   input  wire logic [FRAC_BITS:0]    in_quo [lcl_pkg::NUM_EDGES],
   input  wire logic [lcl_pkg::ROOT_W-1:0] in_root,
   output logic                       rsp_strobe,
   output lcl_pkg::rsp_type           rsp_data
);
   import lcl_pkg::*;

   localparam int QW    = FRAC_BITS + 1;
   localparam int PROD_W = QW + ROOT_W;
   localparam int SHR_W = PROD_W - FRAC_BITS;

   // Stage A: merge entry and exit ratios
   logic              va_ff, rja_ff;
   logic [QW-1:0]     t1_ff, t2_ff, t1_in, t2_in;
   logic [ROOT_W-1:0] maga_ff;
   logic              rj_in;

   always_comb begin
      t1_in = '0;
      t2_in = QW'(1) << FRAC_BITS;
      rj_in = 1'b0;
      for (int e = 0; e < NUM_EDGES; e++) begin
         if (in_ctl[e].entry && (in_quo[e] > t1_in)) t1_in = in_quo[e];
         if (in_ctl[e].leave && (in_quo[e] < t2_in)) t2_in = in_quo[e];
         rj_in = rj_in | in_ctl[e].reject;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) va_ff <= 1'b0;
      else       va_ff <= in_valid;
      t1_ff   <= t1_in;
      t2_ff   <= t2_in;
      rja_ff  <= rj_in;
      maga_ff <= in_root;
   end

   // Stage B: empty interval check and span
   logic              vb_ff, rjb_ff;
   logic [QW-1:0]     span_ff;
   logic [ROOT_W-1:0] magb_ff;

   always_ff @(posedge clock) begin
      if (reset) vb_ff <= 1'b0;
      else       vb_ff <= va_ff;
      rjb_ff  <= rja_ff | (t1_ff > t2_ff);
      span_ff <= t2_ff - t1_ff;
      magb_ff <= maga_ff;
   end

   // Stage C: span times magnitude
   logic              vc_ff, rjc_ff;
   logic [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (reset) vc_ff <= 1'b0;
      else       vc_ff <= vb_ff;
      rjc_ff  <= rjb_ff;
      prod_ff <= PROD_W'(span_ff) * PROD_W'(magb_ff);
   end

   // Stage D: scale, saturate, drive result
   logic [SHR_W-1:0] shr;
   logic [LEN_W-1:0] len_in;
   logic             strobe_ff;
   rsp_type          data_ff;

   assign shr    = prod_ff[PROD_W-1:FRAC_BITS];
   assign len_in = (shr > SHR_W'({LEN_W{1'b1}})) ? {LEN_W{1'b1}} : LEN_W'(shr);

   always_ff @(posedge clock) begin
      if (reset) strobe_ff <= 1'b0;
      else       strobe_ff <= vc_ff;
      data_ff.clipped_length <= rjc_ff ? '0 : len_in;
      data_ff.accepted       <= !rjc_ff;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = data_ff;

endmodule

`default_nettype wire

// ===== rtl/line_clip_length_core.sv =====
// Pipeline: a request taken on start passes four setup stages, 25 bit stages of
// the square root, and four merge stages before the result strobe rises.
// Throughput: one request per cycle; busy stays low and the receiver cannot stall.
// Reset: synchronous, active high; clears every stage valid, in-flight requests are dropped.
`timescale 1ns / 1ps
`default_nettype none

module line_clip_length_core #(
   parameter int PARAM_FRAC_BITS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire lcl_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output lcl_pkg::rsp_type      rsp_data
);
   import lcl_pkg::*;

   localparam int QW   = PARAM_FRAC_BITS + 1;
   localparam int NSTG = (ROOT_W > QW) ? ROOT_W : QW;
   localparam int LAT  = NSTG + 8;

   logic             p_valid;
   edge_set_type     p_ctl;
   logic [DEN_W-1:0] p_den [NUM_EDGES];
   logic [DEN_W-1:0] p_num [NUM_EDGES];
   logic [RAD_W-1:0] p_rad;

   logic              i_valid;
   edge_set_type      i_ctl;
   logic [QW-1:0]     i_quo [NUM_EDGES];
   logic [ROOT_W-1:0] i_root;

   // Fully pipelined: a request can enter every cycle
   assign busy = 1'b0;

   lcl_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_req    (req_data),
      .out_valid (p_valid),
      .out_ctl   (p_ctl),
      .out_den   (p_den),
      .out_num   (p_num),
      .out_rad   (p_rad)
   );

   lcl_iter #(.FRAC_BITS(PARAM_FRAC_BITS)) u_iter (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid),
      .in_ctl    (p_ctl),
      .in_den    (p_den),
      .in_num    (p_num),
      .in_rad    (p_rad),
      .out_valid (i_valid),
      .out_ctl   (i_ctl),
      .out_quo   (i_quo),
      .out_root  (i_root)
   );

   lcl_final #(.FRAC_BITS(PARAM_FRAC_BITS)) u_final (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (i_valid),
      .in_ctl     (i_ctl),
      .in_quo     (i_quo),
      .in_root    (i_root),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTH
   // Every accepted request yields a result after the fixed latency
   a_lat : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_strobe)
      else $error("missing result after request");

   // No result without a request the fixed latency earlier
   a_src : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, LAT))
      else $error("result without request");

   // A rejected segment reports zero length
   a_rej : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.accepted) |-> (rsp_data.clipped_length == '0))
      else $error("rejected segment with nonzero length");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_line_clip_length_core.sv =====
`timescale 1ns / 1ps

module tb_line_clip_length_core;
   import lcl_pkg::*;

   localparam int FRAC      = 16;
   localparam int LATENCY   = 33;
   localparam int IDLE_MAX  = 2000;
   localparam int N_RANDOM  = 600;
   localparam longint LEN_SAT = 64'h1FF_FFFF;

   // Expected clip results, oldest first
   class clip_scoreboard;
      rsp_type pending[$];
      int      errors;

      function new();
         errors = 0;
      endfunction

      // Fixed-point Liang-Barsky clip of one request
      function rsp_type clip_predict(req_type r);
         longint dx, dy, t1, t2, sq, root, rem, trial, len;
         longint p[4], q[4];
         bit     rej;
         rsp_type o;
         dx = longint'(r.end_x) - longint'(r.start_x);
         dy = longint'(r.end_y) - longint'(r.start_y);
         p[0] = -dx; q[0] = longint'(r.start_x) - longint'(r.rect_left);
         p[1] = dx;  q[1] = longint'(r.rect_right) - longint'(r.start_x);
         p[2] = -dy; q[2] = longint'(r.start_y) - longint'(r.rect_top);
         p[3] = dy;  q[3] = longint'(r.rect_bottom) - longint'(r.start_y);
         t1 = 0;
         t2 = longint'(1) << FRAC;
         rej = 0;
         for (int e = 0; e < 4; e++) begin
            if (p[e] == 0) begin
               if (q[e] < 0) rej = 1;
            end else if (p[e] < 0) begin
               if (q[e] < 0) begin
                  if (-q[e] > -p[e]) rej = 1;
                  else if (((-q[e]) << FRAC) / (-p[e]) > t1)
                     t1 = ((-q[e]) << FRAC) / (-p[e]);
               end
            end else begin
               if (q[e] < 0) rej = 1;
               else if (q[e] < p[e] && ((q[e] << FRAC) / p[e]) < t2)
                  t2 = (q[e] << FRAC) / p[e];
            end
         end
         if (t1 > t2) rej = 1;
         o = '0;
         if (!rej) begin
            // floor(sqrt(sq) * 256): integer root of sq << 16, up to 50 bits
            sq = dx * dx + dy * dy;
            root = 0;
            rem = 0;
            for (int i = 0; i < 25; i++) begin
               rem = (rem << 2) | (((sq << 16) >> (48 - 2 * i)) & 3);
               trial = (root << 2) | 1;
               root = root << 1;
               if (rem >= trial) begin
                  rem -= trial;
                  root |= 1;
               end
            end
            len = ((t2 - t1) * root) >> FRAC;
            if (len > LEN_SAT) len = LEN_SAT;
            o.clipped_length = len[LEN_W-1:0];
            o.accepted = 1'b1;
         end
         return o;
      endfunction

      function void note_request(req_type r);
         pending.push_back(clip_predict(r));
      endfunction

      task check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report("result with nothing pending", 0, 0);
            return;
         end
         want = pending.pop_front();
         if (got.clipped_length !== want.clipped_length)
            report("clipped_length", longint'(got.clipped_length),
                   longint'(want.clipped_length));
         if (got.accepted !== want.accepted)
            report("accepted", longint'(got.accepted), longint'(want.accepted));
      endtask

      task report(string what, longint got, longint want);
         $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
         errors++;
      endtask
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   clip_scoreboard sb = new();
   int  idle_cycles = 0;
   bit  quiet = 0;

   line_clip_length_core #(.PARAM_FRAC_BITS(FRAC)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   // Scoreboard hooks and watchdog at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) sb.check_result(rsp_data);
         if (start && !busy) sb.note_request(req_data);
         if ((start && !busy) || rsp_strobe) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_MAX) begin
            $display("tb_line_clip_length_core: done, errors");
            $finish;
         end
      end
   end

   // Drive one request; held until taken, start left high for back-to-back
   task send_request(req_type r);
      if (!quiet) begin
         while ($urandom_range(99) < 6) begin
            start <= 1'b0;
            @(negedge clock);
         end
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task send_seg(int sx, int sy, int ex, int ey, int l, int t, int rr, int b);
      req_type r;
      r.start_x = COORD_W'(sx); r.start_y = COORD_W'(sy);
      r.end_x = COORD_W'(ex); r.end_y = COORD_W'(ey);
      r.rect_left = COORD_W'(l); r.rect_top = COORD_W'(t);
      r.rect_right = COORD_W'(rr); r.rect_bottom = COORD_W'(b);
      send_request(r);
   endtask

   function automatic int rcoord(int span);
      return $urandom_range(2 * span) - span;
   endfunction

   initial begin
      req_type r;
      int l, t, w, h;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: crossing, inside, outside, parallel, point, extremes
      send_seg(-10, 0, 10, 0, -5, -5, 5, 5);
      send_seg(-2, -2, 2, 2, -5, -5, 5, 5);
      send_seg(10, 10, 20, 20, -5, -5, 5, 5);
      send_seg(-10, 6, 10, 6, -5, -5, 5, 5);
      send_seg(6, -10, 6, 10, -5, -5, 5, 5);
      send_seg(0, -10, 0, 10, -5, -5, 5, 5);
      send_seg(1, 1, 1, 1, -5, -5, 5, 5);
      send_seg(9, 9, 9, 9, -5, -5, 5, 5);
      send_seg(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
      send_seg(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
      send_seg(-32768, 0, 32767, 0, 0, 0, 0, 0);
      send_seg(-10, -10, 10, 10, 5, 5, -5, -5);
      send_seg(5, 0, 10, 0, -5, -5, 5, 5);
      send_seg(10, 0, 5, 0, -5, -5, 5, 5);
      send_seg(-10, 5, 5, -10, -5, -5, 5, 5);
      send_seg(-10, 20, 20, -10, -5, -5, 5, 5);
      send_seg(3, 7, 3, 7, 3, 7, 3, 7);
      send_seg(-1, -1, 32767, 32767, 0, 0, 0, 0);
      start <= 1'b0;

      // Drain fully before the random part
      while (sb.pending.size() != 0) @(negedge clock);

      for (int n = 0; n < N_RANDOM; n++) begin
         quiet = (n >= 200 && n < 320);
         case ($urandom_range(9))
            0, 1: r = req_type'({$urandom, $urandom, $urandom, $urandom});
            2, 3: begin
               l = rcoord(30); t = rcoord(30); w = $urandom_range(40); h = $urandom_range(40);
               r.start_x = COORD_W'(rcoord(60)); r.start_y = COORD_W'(rcoord(60));
               r.end_x = COORD_W'(rcoord(60)); r.end_y = COORD_W'(rcoord(60));
               r.rect_left = COORD_W'(l); r.rect_top = COORD_W'(t);
               r.rect_right = COORD_W'(l + w); r.rect_bottom = COORD_W'(t + h);
            end
            default: begin
               l = rcoord(16000); t = rcoord(16000);
               w = $urandom_range(16000); h = $urandom_range(16000);
               r.start_x = COORD_W'(rcoord(32000)); r.start_y = COORD_W'(rcoord(32000));
               r.end_x = COORD_W'(rcoord(32000)); r.end_y = COORD_W'(rcoord(32000));
               if ($urandom_range(3) == 0) r.end_x = r.start_x;
               if ($urandom_range(3) == 0) r.end_y = r.start_y;
               r.rect_left = COORD_W'(l); r.rect_top = COORD_W'(t);
               r.rect_right = COORD_W'(l + w); r.rect_bottom = COORD_W'(t + h);
            end
         endcase
         send_request(r);
      end
      start <= 1'b0;

      while (sb.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("tb_line_clip_length_core: done, clean");
      else
         $display("tb_line_clip_length_core: done, errors");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/lcl_pkg.sv
rtl/lcl_prep.sv
rtl/lcl_iter.sv
rtl/lcl_final.sv
rtl/line_clip_length_core.sv
tb/tb_line_clip_length_core.sv
